// ===== rtl/pfa_pkg.sv =====
// Shared types, constants and codes for the page frame allocator.
// No dependencies; the other files that use it refer to it by scoped names.
`default_nettype none
package pfa_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int CNT_W      = FRAME_W + 1;
    localparam int PID_W      = 8;
    localparam int VPN_W      = 10;
    localparam int OP_W       = 3;
    localparam int CFG_W      = 7;

    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [CNT_W-1:0]   t_cnt;

    // operation codes on the input word
    localparam logic [OP_W-1:0] OP_ALLOC_DATA  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_STACK = 3'd1;
    localparam logic [OP_W-1:0] OP_REL_OLDEST  = 3'd2;
    localparam logic [OP_W-1:0] OP_REL_PID     = 3'd3;
    localparam logic [OP_W-1:0] OP_EVICT       = 3'd4;
    localparam logic [OP_W-1:0] OP_TOUCH       = 3'd5;
    localparam logic [OP_W-1:0] OP_DIRTY       = 3'd6;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_REL_OLD,
        K_REL_PID,
        K_EVICT,
        K_TOUCH,
        K_DIRTY,
        K_NOP
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [PID_W-1:0]  pid;
        logic [VPN_W-1:0]  vpn;
        logic              stk;
    } t_cmd;

    typedef struct packed {
        t_frame            frame;
        logic [PID_W-1:0]  pid;
        logic [VPN_W-1:0]  vpn;
        logic              stk;
        logic              dirty;
    } t_entry;

    typedef struct packed {
        logic              ok;
        t_frame            frame;
        logic [PID_W-1:0]  vpid;
        logic [VPN_W-1:0]  vvpn;
        logic              vstk;
        t_cnt              rel;
        t_cnt              free;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_FIND,
        S_PICK,
        S_APPLY,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/pfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pfa_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/pfa_front.sv =====
// Front end: two-entry command queue that decodes operation codes.
// Depends on pfa_pkg.
`default_nettype none
module pfa_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [pfa_pkg::OP_W-1:0]   i_operation,
    input  wire logic [pfa_pkg::PID_W-1:0]  i_pid,
    input  wire logic [pfa_pkg::VPN_W-1:0]  i_vpn,
    input  wire logic                       i_stack_flag,
    output logic                            o_cmd_valid,
    output pfa_pkg::t_cmd                   o_cmd,
    input  wire logic                       i_cmd_take
);

    pfa_pkg::t_cmd r_q [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    pfa_pkg::t_cmd n_cmd;
    logic          acc;
    logic          take;

    // classify the incoming word
    always_comb begin
        n_cmd     = '0;
        n_cmd.pid = i_pid;
        n_cmd.vpn = i_vpn;
        n_cmd.stk = i_stack_flag;
        unique case (i_operation)
            pfa_pkg::OP_ALLOC_DATA: begin
                n_cmd.kind = pfa_pkg::K_ALLOC;
                n_cmd.stk  = 1'b0;
            end
            pfa_pkg::OP_ALLOC_STACK: begin
                n_cmd.kind = pfa_pkg::K_ALLOC;
                n_cmd.stk  = 1'b1;
            end
            pfa_pkg::OP_REL_OLDEST: n_cmd.kind = pfa_pkg::K_REL_OLD;
            pfa_pkg::OP_REL_PID:    n_cmd.kind = pfa_pkg::K_REL_PID;
            pfa_pkg::OP_EVICT:      n_cmd.kind = pfa_pkg::K_EVICT;
            pfa_pkg::OP_TOUCH:      n_cmd.kind = pfa_pkg::K_TOUCH;
            pfa_pkg::OP_DIRTY:      n_cmd.kind = pfa_pkg::K_DIRTY;
            default:                n_cmd.kind = pfa_pkg::K_NOP;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign acc         = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign take        = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wr <= !r_wr;
            end
            if (take) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(acc) - 2'(take);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/pfa_back.sv =====
// Back end: sequencer over the used-page cells and the free frame queue.
// Depends on pfa_pkg and pfa_ram.
`default_nettype none
module pfa_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [pfa_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire logic                       i_cmd_valid,
    input  wire pfa_pkg::t_cmd              i_cmd,
    output logic                            o_cmd_take,
    input  wire logic                       i_pop,
    output logic                            o_res_valid,
    output pfa_pkg::t_res                   o_res
);

    localparam int N = pfa_pkg::MAX_FRAMES;
    localparam int FW = pfa_pkg::FRAME_W;
    localparam int CW = pfa_pkg::CNT_W;

    pfa_pkg::t_state   r_state, n_state;
    pfa_pkg::t_cmd     r_cmd;
    pfa_pkg::t_entry   r_cells [N];
    pfa_pkg::t_cnt     r_used;
    pfa_pkg::t_cnt     r_free;
    pfa_pkg::t_frame   r_head;
    pfa_pkg::t_frame   r_n;
    pfa_pkg::t_cnt     r_wcnt;
    logic [N-1:0]      r_m;
    logic [N-1:0]      r_ge;
    logic [N-1:0]      r_first;
    logic              r_hit;
    pfa_pkg::t_entry   r_ent;
    pfa_pkg::t_cnt     r_rel;
    pfa_pkg::t_frame   r_rfirst;
    pfa_pkg::t_res     r_pend;
    pfa_pkg::t_res     r_res;
    logic              r_res_v;

    logic [N-1:0]      m_next;
    logic [N-1:0]      ge_next;
    logic [N-1:0]      first_next;
    pfa_pkg::t_entry   ent_sel;
    pfa_pkg::t_frame   rdata;
    pfa_pkg::t_frame   alloc_frame;
    pfa_pkg::t_frame   slot_ofs;
    pfa_pkg::t_frame   tail;
    pfa_pkg::t_cnt     n_cfg;
    logic              alloc_ok;
    logic              frees;
    logic              ram_we;

    // free frame queue; entries not yet written since load read as their index
    pfa_ram #(.W(FW), .D(N)) u_freeq (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (tail),
        .i_wdata (r_ent.frame),
        .i_raddr (r_head),
        .o_rdata (rdata)
    );

    assign slot_ofs    = r_head - r_n;
    assign alloc_frame = ({1'b0, slot_ofs} < r_wcnt) ? rdata : r_head;
    assign tail        = r_head + r_free[FW-1:0];
    assign alloc_ok    = (r_free != '0) && (r_used < CW'(N));
    assign n_cfg       = (int'(i_cfg_wdata) > N) ? CW'(N) : CW'(i_cfg_wdata);
    assign frees       = (r_cmd.kind == pfa_pkg::K_REL_OLD) ||
                         (r_cmd.kind == pfa_pkg::K_REL_PID) ||
                         (r_cmd.kind == pfa_pkg::K_EVICT);

    // per-cell match
    always_comb begin
        for (int i = 0; i < N; i++) begin
            logic vld;
            vld = (CW'(i) < r_used);
            unique case (r_cmd.kind)
                pfa_pkg::K_REL_OLD: m_next[i] = vld && (i == 0);
                pfa_pkg::K_REL_PID: m_next[i] = vld && (r_cells[i].pid == r_cmd.pid);
                pfa_pkg::K_EVICT:   m_next[i] = vld && !r_cells[i].dirty;
                pfa_pkg::K_TOUCH,
                pfa_pkg::K_DIRTY:   m_next[i] = vld && (r_cells[i].pid == r_cmd.pid) &&
                                                (r_cells[i].vpn == r_cmd.vpn) &&
                                                (r_cells[i].stk == r_cmd.stk);
                default:            m_next[i] = 1'b0;
            endcase
        end
    end

    // prefix OR: thermometer from the oldest match upward
    always_comb begin
        ge_next = r_m;
        for (int k = 1; k < N; k = k * 2) begin
            ge_next = ge_next | (ge_next << k);
        end
    end

    // one-hot oldest match and its entry
    assign first_next = r_ge & ~(r_ge << 1);
    always_comb begin
        ent_sel = '0;
        for (int i = 0; i < N; i++) begin
            ent_sel = ent_sel | (first_next[i] ? r_cells[i] : '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfa_pkg::S_IDLE:  if (i_cmd_valid) n_state = pfa_pkg::S_MATCH;
            pfa_pkg::S_MATCH: n_state = pfa_pkg::S_FIND;
            pfa_pkg::S_FIND:  n_state = pfa_pkg::S_PICK;
            pfa_pkg::S_PICK:  n_state = pfa_pkg::S_APPLY;
            pfa_pkg::S_APPLY: begin
                if (r_cmd.kind == pfa_pkg::K_REL_PID && r_hit) begin
                    n_state = pfa_pkg::S_MATCH;
                end else begin
                    n_state = pfa_pkg::S_OUT;
                end
            end
            pfa_pkg::S_OUT:   if (!r_res_v) n_state = pfa_pkg::S_IDLE;
            default:          n_state = pfa_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_take = 1'b0;
        ram_we     = 1'b0;
        unique case (r_state)
            pfa_pkg::S_IDLE:  o_cmd_take = 1'b1;
            pfa_pkg::S_APPLY: ram_we = r_hit && frees && (r_free < CW'(N));
            default: ;
        endcase
    end

    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfa_pkg::S_IDLE;
            r_used  <= '0;
            r_free  <= CW'(N);
            r_head  <= '0;
            r_n     <= FW'(N);
            r_wcnt  <= '0;
            r_res_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_pop && r_res_v) begin
                r_res_v <= 1'b0;
            end
            if (r_state == pfa_pkg::S_OUT && !r_res_v) begin
                r_res_v <= 1'b1;
            end
            if (r_state == pfa_pkg::S_APPLY) begin
                if (r_cmd.kind == pfa_pkg::K_ALLOC && alloc_ok) begin
                    r_head <= r_head + 1'b1;
                    r_free <= r_free - 1'b1;
                    r_used <= r_used + 1'b1;
                end
                if (r_hit && frees) begin
                    r_used <= r_used - 1'b1;
                end
                if (ram_we) begin
                    r_free <= r_free + 1'b1;
                    if (r_wcnt < CW'(N)) begin
                        r_wcnt <= r_wcnt + 1'b1;
                    end
                end
            end
            // reload: queue refilled by index, list emptied
            if (i_cfg_we) begin
                r_free <= n_cfg;
                r_n    <= n_cfg[FW-1:0];
                r_head <= '0;
                r_used <= '0;
                r_wcnt <= '0;
            end
        end
    end

    // datapath: command, search registers, cells, results
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pfa_pkg::S_IDLE: begin
                r_cmd    <= i_cmd;
                r_rel    <= '0;
                r_rfirst <= '0;
            end
            pfa_pkg::S_MATCH: r_m <= m_next;
            pfa_pkg::S_FIND: begin
                r_ge  <= ge_next;
                r_hit <= |r_m;
            end
            pfa_pkg::S_PICK: begin
                r_ent   <= ent_sel;
                r_first <= first_next;
            end
            pfa_pkg::S_APPLY: begin
                r_pend <= '0;
                unique case (r_cmd.kind)
                    pfa_pkg::K_ALLOC: begin
                        if (alloc_ok) begin
                            for (int i = 0; i < N; i++) begin
                                if (CW'(i) == r_used) begin
                                    r_cells[i] <= '{frame: alloc_frame, pid: r_cmd.pid,
                                                    vpn: r_cmd.vpn, stk: r_cmd.stk,
                                                    dirty: 1'b0};
                                end
                            end
                            r_pend.ok    <= 1'b1;
                            r_pend.frame <= alloc_frame;
                        end
                    end
                    pfa_pkg::K_DIRTY: begin
                        if (r_hit) begin
                            for (int i = 0; i < N; i++) begin
                                if (r_first[i]) begin
                                    r_cells[i].dirty <= 1'b1;
                                end
                            end
                            r_pend.ok    <= 1'b1;
                            r_pend.frame <= r_ent.frame;
                        end
                    end
                    pfa_pkg::K_NOP: ;
                    default: begin
                        // remove the matched cell by compaction; a touch re-appends it as newest
                        if (r_hit) begin
                            for (int i = 0; i < N - 1; i++) begin
                                if (r_ge[i]) begin
                                    r_cells[i] <= r_cells[i+1];
                                end
                            end
                            if (r_cmd.kind == pfa_pkg::K_TOUCH) begin
                                for (int i = 0; i < N; i++) begin
                                    if (CW'(i) == r_used - 1'b1) begin
                                        r_cells[i] <= r_ent;
                                    end
                                end
                            end
                        end
                        if (r_cmd.kind == pfa_pkg::K_REL_PID) begin
                            if (r_hit) begin
                                r_rel <= r_rel + 1'b1;
                                if (r_rel == '0) begin
                                    r_rfirst <= r_ent.frame;
                                end
                            end else begin
                                r_pend.ok    <= (r_rel != '0);
                                r_pend.frame <= r_rfirst;
                                r_pend.rel   <= r_rel;
                            end
                        end else if (r_hit) begin
                            r_pend.ok    <= 1'b1;
                            r_pend.frame <= r_ent.frame;
                            if (r_cmd.kind == pfa_pkg::K_EVICT) begin
                                r_pend.vpid <= r_ent.pid;
                                r_pend.vvpn <= r_ent.vpn;
                                r_pend.vstk <= r_ent.stk;
                            end
                        end
                    end
                endcase
            end
            pfa_pkg::S_OUT: begin
                if (!r_res_v) begin
                    r_res      <= r_pend;
                    r_res.free <= r_free;
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/page_frame_allocator_lru_unit.sv =====
// Page frame allocator with LRU ordering and clean-only eviction.
// The back-end sequencer steps each accepted word through match, prefix,
//   pick, apply and output; release by pid repeats match to apply per page
//   freed. A new word is taken only from idle, after the last result is out.
// Reset: synchronous, active low; all 64 frames free, used list empty, no
//   clearing pass (untouched queue slots read as their own index).
// Depends on pfa_pkg, pfa_front, pfa_back.
`default_nettype none
module page_frame_allocator_lru_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [pfa_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [pfa_pkg::OP_W-1:0]   i_operation,
    input  wire logic [pfa_pkg::PID_W-1:0]  i_pid,
    input  wire logic [pfa_pkg::VPN_W-1:0]  i_vpn,
    input  wire logic                       i_stack_flag,
    output logic                            empty,
    input  wire logic                       pop,
    output logic                            o_ok,
    output logic [pfa_pkg::FRAME_W-1:0]     o_frame,
    output logic [pfa_pkg::PID_W-1:0]       o_victim_pid,
    output logic [pfa_pkg::VPN_W-1:0]       o_victim_vpn,
    output logic                            o_victim_stack,
    output logic [pfa_pkg::CNT_W-1:0]       o_released_count,
    output logic [pfa_pkg::CNT_W-1:0]       o_free_count
);

    logic          cmd_valid;
    logic          cmd_take;
    pfa_pkg::t_cmd cmd;
    logic          res_valid;
    pfa_pkg::t_res res;

    pfa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_operation  (i_operation),
        .i_pid        (i_pid),
        .i_vpn        (i_vpn),
        .i_stack_flag (i_stack_flag),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_take   (cmd_take)
    );

    pfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_pop       (pop),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result word
    assign empty            = !res_valid;
    assign o_ok             = res.ok;
    assign o_frame          = res.frame;
    assign o_victim_pid     = res.vpid;
    assign o_victim_vpn     = res.vvpn;
    assign o_victim_stack   = res.vstk;
    assign o_released_count = res.rel;
    assign o_free_count     = res.free;

endmodule
`default_nettype wire

// ===== rtl/pfa_checker.sv =====
// Port-level checks for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_allocator_lru_unit.
`default_nettype none
module pfa_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       empty,
    input wire logic                       pop,
    input wire logic                       o_ok,
    input wire logic [pfa_pkg::FRAME_W-1:0] o_frame,
    input wire logic [pfa_pkg::CNT_W-1:0]  o_released_count,
    input wire logic [pfa_pkg::CNT_W-1:0]  o_free_count
);

    // nothing waits right after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result word present after reset");

    // free count never exceeds the frame pool
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_free_count <= pfa_pkg::CNT_W'(pfa_pkg::MAX_FRAMES))
        else $error("free count out of range");

    // a released count only comes with success
    a_rel_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_ok) |-> (o_released_count == '0 && o_frame == '0))
        else $error("failed word carries frame or released count");

    // waiting word holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_free_count) && $stable(o_ok)))
        else $error("result word changed while waiting");

endmodule

bind page_frame_allocator_lru_unit pfa_checker u_pfa_checker (.*);
`default_nettype wire
